>>> hw/rtl/rtxb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rtxb_pkg;
	localparam logic [15:0] WHITE_X = 16'd20493;
	localparam logic [15:0] WHITE_Y = 16'd21561;
	localparam logic [19:0] MXR = 20'd664511;
	localparam logic [19:0] MXG = 20'd154324;
	localparam logic [19:0] MXB = 20'd162028;
	localparam logic [19:0] MYR = 20'd283881;
	localparam logic [19:0] MYG = 20'd668433;
	localparam logic [19:0] MYB = 20'd47685;
	localparam logic [19:0] MZR = 20'd88;
	localparam logic [19:0] MZG = 20'd72310;
	localparam logic [19:0] MZB = 20'd986039;

	function automatic longint unsigned pow5(input longint unsigned r);
		longint unsigned p2;
		longint unsigned p4;
		p2 = (r * r) >> 30;
		p4 = (p2 * p2) >> 30;
		return (p4 * r) >> 30;
	endfunction

	// Linearized sRGB code c as unsigned Q1.fb.
	function automatic logic [24:0] lin(input logic [7:0] c, input int fb);
		longint unsigned k;
		longint unsigned t;
		longint unsigned s;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned p;
		if (c <= 8'd10) begin
			k = ((64'(c) * 10) << (fb + 1)) + 32946;
			return 25'(k / 65892);
		end
		t = ((64'(c) * 1000 + 14025) << 30) / 269025;
		s = (t * t) >> 30;
		lo = 0;
		hi = 64'd1 << 30;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (pow5(mid) <= s)
				lo = mid;
			else
				hi = mid - 1;
		end
		p = (s * lo) >> 30;
		return 25'((p + (64'd1 << (29 - fb))) >> (30 - fb));
	endfunction
endpackage
`default_nettype wire

>>> hw/rtl/rgb_to_xy_brightness.sv
`timescale 1ns / 1ps
`default_nettype none
// Converts one sRGB color with brightness and transition time per transfer.
// Input channel s_axis_*, result channel m_axis_*, both valid/ready.
// A new transfer can be accepted every cycle while the receiver takes results.
// The pipeline has 19 register stages: the linearization table lookup, the
// color matrix, the chromaticity sum, and 16 divider stages that each give
// one quotient bit.
// Reset clears all valid bits; no result is produced until new input arrives.
// When the receiver stalls, the whole pipeline holds and s_axis_tready is low
// in every cycle in which a result waits on m_axis.
module rgb_to_xy_brightness #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// red[7:0], green[15:8], blue[23:16], brightness[31:24], transition_q8[52:32]
	input  wire logic [55:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// light_on[0], x_chroma[16:1], y_chroma[32:17], level[40:33], tenths[56:41]
	output logic [63:0]      m_axis_tdata
);
	localparam int LW = FRAC_BITS + 1;
	localparam int SW = LW + 22;
	localparam int NS = 19;

	logic [NS-1:0] vld_q;
	logic          adv;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	logic [LW-1:0] r_s1, g_s1, b_s1;
	logic [7:0]    bri_s1, bri_s2;
	logic [20:0]   q_s1;
	logic [15:0]   ten_s2;
	logic [SW-1:0] x_s2, y_s2, z_s2;
	logic [SW+15:0] rx [16:0];
	logic [SW+15:0] ry [16:0];
	logic [15:0]   qx [16:0];
	logic [15:0]   qy [16:0];
	logic [SW-1:0] dv [16:0];
	logic [7:0]    lv [16:0];
	logic          on [16:0];
	logic [15:0]   tn [16:0];
	logic [LW-1:0] lin_tab [256];

	for (genvar c = 0; c < 256; c++) begin : g_lin
		assign lin_tab[c] = LW'(rtxb_pkg::lin(8'(c), FRAC_BITS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[NS-2:0], s_axis_tvalid};
	end
	assign m_axis_tvalid = vld_q[NS-1];

	logic [25:0] tq;
	logic [15:0] lvp;
	logic [16:0] lvd;
	assign tq = ({5'd0, q_s1} * 26'd10 + 26'd128) >> 8;
	assign lvp = {8'd0, bri_s2} * 16'd253;
	assign lvd = {1'b0, lvp} + {9'd0, lvp[15:8]} + 17'd1;

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1 <= lin_tab[s_axis_tdata[7:0]];
			g_s1 <= lin_tab[s_axis_tdata[15:8]];
			b_s1 <= lin_tab[s_axis_tdata[23:16]];
			bri_s1 <= s_axis_tdata[31:24];
			q_s1 <= s_axis_tdata[52:32];
			bri_s2 <= bri_s1;
			ten_s2 <= (tq > 26'd65535) ? 16'hFFFF : tq[15:0];
			x_s2 <= SW'(rtxb_pkg::MXR) * SW'(r_s1) + SW'(rtxb_pkg::MXG) * SW'(g_s1)
				+ SW'(rtxb_pkg::MXB) * SW'(b_s1);
			y_s2 <= SW'(rtxb_pkg::MYR) * SW'(r_s1) + SW'(rtxb_pkg::MYG) * SW'(g_s1)
				+ SW'(rtxb_pkg::MYB) * SW'(b_s1);
			z_s2 <= SW'(rtxb_pkg::MZR) * SW'(r_s1) + SW'(rtxb_pkg::MZG) * SW'(g_s1)
				+ SW'(rtxb_pkg::MZB) * SW'(b_s1);
			rx[0] <= {x_s2, 16'd0};
			ry[0] <= {y_s2, 16'd0};
			dv[0] <= x_s2 + y_s2 + z_s2;
			qx[0] <= '0;
			qy[0] <= '0;
			lv[0] <= (bri_s2 == 8'd0) ? 8'd1 : lvd[15:8] + 8'd1;
			on[0] <= bri_s2 != 8'd0;
			tn[0] <= ten_s2;
		end
	end

	for (genvar i = 0; i < 16; i++) begin : g_div
		logic [SW+15:0] dsh;
		assign dsh = {16'd0, dv[i]} << (15 - i);
		always_ff @(posedge clk) begin
			if (adv) begin
				rx[i+1] <= (rx[i] >= dsh) ? rx[i] - dsh : rx[i];
				ry[i+1] <= (ry[i] >= dsh) ? ry[i] - dsh : ry[i];
				qx[i+1] <= {qx[i][14:0], rx[i] >= dsh};
				qy[i+1] <= {qy[i][14:0], ry[i] >= dsh};
				dv[i+1] <= dv[i];
				lv[i+1] <= lv[i];
				on[i+1] <= on[i];
				tn[i+1] <= tn[i];
			end
		end
	end

	logic [15:0] xo, yo;
	assign xo = (dv[16] == '0) ? rtxb_pkg::WHITE_X : qx[16];
	assign yo = (dv[16] == '0) ? rtxb_pkg::WHITE_Y : qy[16];
	assign m_axis_tdata = {7'd0, tn[16], lv[16], yo, xo, on[16]};

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result dropped during stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (lv[16] != 8'd0 && lv[16] <= 8'd254))
		else $error("level out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !on[16]) |-> lv[16] == 8'd1)
		else $error("off level not one");
endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
module tb;
	typedef struct packed {
		logic [15:0] tenths;
		logic [7:0]  level;
		logic [15:0] y_chroma;
		logic [15:0] x_chroma;
		logic        light_on;
	} lamp_t;

	typedef struct {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  bright;
		logic [20:0] trans;
		bit          typed;
		lamp_t       want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;

	longint unsigned lin_tab [256];
	lamp_t           lamp_q [$];
	int              err_count = 0;
	bit              quiet = 1'b0;

	rgb_to_xy_brightness DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned pow5(longint unsigned r);
		longint unsigned p2;
		longint unsigned p4;
		p2 = (r * r) >> 30;
		p4 = (p2 * p2) >> 30;
		return (p4 * r) >> 30;
	endfunction

	function automatic longint unsigned linearize(int c);
		longint unsigned t;
		longint unsigned s;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned p;
		if (c <= 10)
			return ((longint'(c) * 10 << 17) + 32946) / 65892;
		t = ((longint'(1000 * c + 14025)) << 30) / 269025;
		s = (t * t) >> 30;
		lo = 0;
		hi = 64'd1 << 30;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (pow5(mid) <= s)
				lo = mid;
			else
				hi = mid - 1;
		end
		p = (s * lo) >> 30;
		return (p + (64'd1 << 13)) >> 14;
	endfunction

	function automatic lamp_t lamp_of(logic [7:0] rd, logic [7:0] gr, logic [7:0] bl,
			logic [7:0] bri, logic [20:0] q);
		longint unsigned r;
		longint unsigned g;
		longint unsigned b;
		longint unsigned cx;
		longint unsigned cy;
		longint unsigned sum;
		longint unsigned tn;
		lamp_t o;
		r = lin_tab[rd];
		g = lin_tab[gr];
		b = lin_tab[bl];
		cx = 664511 * r + 154324 * g + 162028 * b;
		cy = 283881 * r + 668433 * g + 47685 * b;
		sum = cx + cy + 88 * r + 72310 * g + 986039 * b;
		if (sum == 0) begin
			o.x_chroma = rtxb_pkg::WHITE_X;
			o.y_chroma = rtxb_pkg::WHITE_Y;
		end else begin
			o.x_chroma = 16'((cx << 16) / sum);
			o.y_chroma = 16'((cy << 16) / sum);
		end
		tn = (longint'(q) * 10 + 128) >> 8;
		o.tenths = (tn > 65535) ? 16'hFFFF : 16'(tn);
		o.light_on = (bri != 0);
		o.level = (bri == 0) ? 8'd1 : 8'((int'(bri) * 253) / 255 + 1);
		return o;
	endfunction

	task automatic report(string what, int got, int exp_v);
		$display("mismatch %s: got %0d, expected %0d", what, got, exp_v);
		err_count++;
	endtask

	task automatic send(logic [7:0] rd, logic [7:0] gr, logic [7:0] bl, logic [7:0] bri,
			logic [20:0] q, bit typed, lamp_t want);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b0, q, bri, bl, gr, rd};
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		lamp_q.push_back(typed ? want : lamp_of(rd, gr, bl, bri, q));
	endtask

	// Receiver: random stall bursts.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// Result checking on the falling edge, where the handshake signals are stable.
	always @(negedge clk) begin
		lamp_t got;
		lamp_t exp_v;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[56:0];
			if (lamp_q.size() == 0) begin
				report("unexpected result transfer", 0, 0);
			end else begin
				exp_v = lamp_q.pop_front();
				if (got.light_on !== exp_v.light_on)
					report("light_on", int'(got.light_on), int'(exp_v.light_on));
				if (got.x_chroma !== exp_v.x_chroma)
					report("x_chroma", int'(got.x_chroma), int'(exp_v.x_chroma));
				if (got.y_chroma !== exp_v.y_chroma)
					report("y_chroma", int'(got.y_chroma), int'(exp_v.y_chroma));
				if (got.level !== exp_v.level)
					report("level", int'(got.level), int'(exp_v.level));
				if (got.tenths !== exp_v.tenths)
					report("tenths", int'(got.tenths), int'(exp_v.tenths));
			end
		end
	end

	initial begin
		#3ms;
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		stim_row_t rows [$];
		stim_row_t row;
		int n;
		int k;
		logic [7:0] c;
		for (int i = 0; i < 256; i++)
			lin_tab[i] = linearize(i);

		// Black, off, zero time: white point, level 1.
		rows.push_back('{8'd0, 8'd0, 8'd0, 8'd0, 21'd0, 1,
			'{16'd0, 8'd1, rtxb_pkg::WHITE_Y, rtxb_pkg::WHITE_X, 1'b0}});
		// Black, full brightness, longest time saturates.
		rows.push_back('{8'd0, 8'd0, 8'd0, 8'd255, 21'h1FFFFF, 1,
			'{16'hFFFF, 8'd254, rtxb_pkg::WHITE_Y, rtxb_pkg::WHITE_X, 1'b1}});
		// Black, brightness 1 gives level 1, one second is ten tenths.
		rows.push_back('{8'd0, 8'd0, 8'd0, 8'd1, 21'd256, 1,
			'{16'd10, 8'd1, rtxb_pkg::WHITE_Y, rtxb_pkg::WHITE_X, 1'b1}});
		rows.push_back('{8'd255, 8'd255, 8'd255, 8'd255, 21'd0, 0, '0});
		rows.push_back('{8'd255, 8'd0, 8'd0, 8'd128, 21'd12, 0, '0});
		rows.push_back('{8'd0, 8'd255, 8'd0, 8'd0, 21'd13, 0, '0});
		rows.push_back('{8'd0, 8'd0, 8'd255, 8'd254, 21'd1677696, 0, '0});
		rows.push_back('{8'd10, 8'd10, 8'd10, 8'd2, 21'd1677708, 0, '0});
		rows.push_back('{8'd11, 8'd11, 8'd11, 8'd100, 21'd1677683, 0, '0});
		rows.push_back('{8'd1, 8'd0, 8'd0, 8'd0, 21'h0AAAAA, 0, '0});
		rows.push_back('{8'd0, 8'd1, 8'd0, 8'd170, 21'h155555, 0, '0});
		rows.push_back('{8'd0, 8'd0, 8'd1, 8'd85, 21'd127, 0, '0});
		rows.push_back('{8'd10, 8'd11, 8'd254, 8'd127, 21'd38, 0, '0});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send(rows[i].red, rows[i].green, rows[i].blue, rows[i].bright, rows[i].trans,
				rows[i].typed, rows[i].want);

		n = 550;
		for (k = 0; k < n; k++) begin
			if (k == 200 || k == 400) begin
				s_axis_tvalid <= 1'b0;
				while (lamp_q.size() != 0) @(posedge clk);
			end
			if (k == n - 60)
				quiet = 1'b1;
			row.red = 8'($urandom);
			row.green = 8'($urandom);
			row.blue = 8'($urandom);
			case ($urandom_range(0, 5))
				0: begin
					c = 8'($urandom_range(0, 12));
					row.red = c;
					row.green = 8'($urandom_range(0, 12));
					row.blue = 8'($urandom_range(0, 12));
				end
				1: row.blue = 8'd0;
				default: ;
			endcase
			row.bright = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom);
			case ($urandom_range(0, 3))
				0: row.trans = 21'($urandom_range(0, 2000));
				1: row.trans = 21'($urandom_range(1677000, 2097151));
				default: row.trans = 21'($urandom);
			endcase
			send(row.red, row.green, row.blue, row.bright, row.trans, 0, '0);
		end
		s_axis_tvalid <= 1'b0;

		while (lamp_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (err_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
